// ===== rtl/tbo_pkg.sv =====
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared constants and types for the triangle / box overlap pipeline.
// ----------------------------------------------------------------------------
package tbo_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int HALF_W          = 15;
    localparam int CFG_IDX_W       = 2;

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(8);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z = CFG_IDX_W'(2);

    typedef logic [HALF_W-1:0] t_half;

endpackage

// ===== rtl/tbo_if.sv =====
// ----------------------------------------------------------------------------
// tbo_if
// Channel interfaces: input item, result item and configuration write.
// ----------------------------------------------------------------------------
interface tbo_in_if #(parameter int W = tbo_pkg::COORD_WIDTH_DEF);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] centre_x, centre_y, centre_z;
    logic signed [W-1:0] corner_a_x, corner_a_y, corner_a_z;
    logic signed [W-1:0] corner_b_x, corner_b_y, corner_b_z;
    logic signed [W-1:0] corner_c_x, corner_c_y, corner_c_z;

    modport source (output valid, centre_x, centre_y, centre_z,
                    corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
                    corner_b_z, corner_c_x, corner_c_y, corner_c_z, input ready);
    modport sink   (input valid, centre_x, centre_y, centre_z,
                    corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
                    corner_b_z, corner_c_x, corner_c_y, corner_c_z, output ready);
endinterface

interface tbo_out_if;
    logic valid;
    logic ready;
    logic overlaps;

    modport source (output valid, overlaps, input ready);
    modport sink   (input valid, overlaps, output ready);
endinterface

interface tbo_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tbo_pkg::CFG_IDX_W-1:0]   index;
    logic [tbo_pkg::HALF_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/triangle_box_overlap_test.sv =====
// ----------------------------------------------------------------------------
// triangle_box_overlap_test
// Separating-axis overlap test of one triangle against an axis-aligned box.
// ----------------------------------------------------------------------------
// Each input transaction carries a box centre and three triangle vertices as
// signed COORD_WIDTH-bit fixed point; the box half extents come from three
// configuration registers (index 0..2 = x, y, z, reset 8, writes to other
// indexes are dropped). One result transaction with overlaps = 1 (touching
// counts) follows each input. The block is a six-stage pipeline: a new
// transaction is taken every cycle unless the output is stalled, and the
// stages are relative vertices -> edges -> projections and normal ->
// min/max compares -> split-normal plane products -> plane sums. A stall at
// the output freezes all stages together; bubbles between stages are kept.
// Change the half extents only while the pipeline is empty.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test #(
    parameter int COORD_WIDTH = tbo_pkg::COORD_WIDTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tbo_in_if.sink     i_item,
    tbo_out_if.source  o_result,
    tbo_cfg_if.sink    i_cfg
);
    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * W + 4;
    localparam int DW = ((W + 1) > 16 ? (W + 1) : 16) + 1;

    // half extent registers
    tbo_pkg::t_half r_h [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h[0] <= tbo_pkg::HALF_RESET;
            r_h[1] <= tbo_pkg::HALF_RESET;
            r_h[2] <= tbo_pkg::HALF_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tbo_pkg::CFG_HALF_X: r_h[0] <= i_cfg.data;
                tbo_pkg::CFG_HALF_Y: r_h[1] <= i_cfg.data;
                tbo_pkg::CFG_HALF_Z: r_h[2] <= i_cfg.data;
                default: ;  // unknown index, ignored
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // whole pipe advances unless the result register is full and stalled
    logic adv;
    logic out_vld;
    assign adv          = !out_vld || o_result.ready;
    assign i_item.ready = adv;
    assign o_result.valid = out_vld;

    logic signed [W-1:0] c [3];
    logic signed [W-1:0] t [3][3];

    assign c[0] = i_item.centre_x;
    assign c[1] = i_item.centre_y;
    assign c[2] = i_item.centre_z;
    assign t[0][0] = i_item.corner_a_x;
    assign t[0][1] = i_item.corner_a_y;
    assign t[0][2] = i_item.corner_a_z;
    assign t[1][0] = i_item.corner_b_x;
    assign t[1][1] = i_item.corner_b_y;
    assign t[1][2] = i_item.corner_b_z;
    assign t[2][0] = i_item.corner_c_x;
    assign t[2][1] = i_item.corner_c_y;
    assign t[2][2] = i_item.corner_c_z;

    logic                 f_vld, f_face;
    logic signed [PW-1:0] f_p [3][3][3];
    logic [W+16:0]        f_rad [3][3];
    logic signed [PW-1:0] f_n [3];
    logic signed [W:0]    f_v0 [3];

    tbo_front #(.W(W)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_vld      (i_item.valid),
        .i_c        (c),
        .i_t        (t),
        .i_h        (r_h),
        .o_vld      (f_vld),
        .o_face_sep (f_face),
        .o_p        (f_p),
        .o_rad      (f_rad),
        .o_n        (f_n),
        .o_v0       (f_v0)
    );

    logic                 s_vld, s_sep;
    logic signed [PW-1:0] s_n [3];
    logic signed [DW-1:0] s_dn [3], s_df [3];

    tbo_sep #(.W(W)) u_sep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_vld      (f_vld),
        .i_face_sep (f_face),
        .i_p        (f_p),
        .i_rad      (f_rad),
        .i_n        (f_n),
        .i_v0       (f_v0),
        .i_h        (r_h),
        .o_vld      (s_vld),
        .o_sep      (s_sep),
        .o_n        (s_n),
        .o_dn       (s_dn),
        .o_df       (s_df)
    );

    tbo_plane #(.W(W)) u_plane (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_vld      (s_vld),
        .i_sep      (s_sep),
        .i_n        (s_n),
        .i_dn       (s_dn),
        .i_df       (s_df),
        .o_vld      (out_vld),
        .o_overlaps (o_result.overlaps)
    );
endmodule

// ===== rtl/tbo_front.sv =====
// ----------------------------------------------------------------------------
// tbo_front
// Stages 1-3: relative vertices, edges and face test, axis projections,
// projection radii and triangle normal.
// ----------------------------------------------------------------------------
module tbo_front #(
    parameter int W = tbo_pkg::COORD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_vld,
    input  logic signed [W-1:0]   i_c [3],
    input  logic signed [W-1:0]   i_t [3][3],
    input  tbo_pkg::t_half        i_h [3],
    output logic                  o_vld,
    output logic                  o_face_sep,
    output logic signed [2*W+3:0] o_p [3][3][3],
    output logic [W+16:0]         o_rad [3][3],
    output logic signed [2*W+3:0] o_n [3],
    output logic signed [W:0]     o_v0 [3]
);
    localparam int VW = W + 1;
    localparam int EW = W + 2;
    localparam int PW = 2 * W + 4;
    localparam int RW = W + 17;
    localparam int DW = ((W + 1) > 16 ? (W + 1) : 16) + 1;

    // stage 1
    logic                 r_vld1;
    logic signed [VW-1:0] r_v1 [3][3];
    // stage 2
    logic                 r_vld2;
    logic signed [VW-1:0] r_v2 [3][3];
    logic signed [EW-1:0] r_e2 [3][3];
    logic                 r_face2;
    logic signed [VW-1:0] n_v1 [3][3];
    logic signed [EW-1:0] n_e2 [3][3];
    logic                 n_face2;
    // stage 3
    logic                 r_vld3;
    logic                 r_face3;
    logic signed [PW-1:0] r_p3 [3][3][3];
    logic [RW-1:0]        r_rad3 [3][3];
    logic signed [PW-1:0] r_n3 [3];
    logic signed [VW-1:0] r_v03 [3];
    logic signed [PW-1:0] n_p3 [3][3][3];
    logic [RW-1:0]        n_rad3 [3][3];
    logic signed [PW-1:0] n_n3 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_v1[i][k] = VW'(i_t[i][k]) - VW'(i_c[k]);
            end
        end
    end

    always_comb begin
        logic signed [VW-1:0] mn, mx;
        logic signed [DW-1:0] hs;
        n_face2 = 1'b0;
        for (int k = 0; k < 3; k++) begin
            n_e2[0][k] = EW'(r_v1[1][k]) - EW'(r_v1[0][k]);
            n_e2[1][k] = EW'(r_v1[2][k]) - EW'(r_v1[1][k]);
            n_e2[2][k] = EW'(r_v1[0][k]) - EW'(r_v1[2][k]);
            mn = r_v1[0][k];
            mx = r_v1[0][k];
            for (int i = 1; i < 3; i++) begin
                if (r_v1[i][k] < mn) mn = r_v1[i][k];
                if (r_v1[i][k] > mx) mx = r_v1[i][k];
            end
            hs = $signed(DW'(i_h[k]));
            if ((DW'(mn) > hs) || (DW'(mx) < -hs)) n_face2 = 1'b1;
        end
    end

    always_comb begin
        logic [EW-1:0] ae_j, ae_l;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                for (int m = 0; m < 3; m++) begin
                    n_p3[i][k][m] =
                        PW'(r_e2[i][(k+2)%3]) * PW'(r_v2[m][(k+1)%3]) -
                        PW'(r_e2[i][(k+1)%3]) * PW'(r_v2[m][(k+2)%3]);
                end
                ae_j = r_e2[i][(k+1)%3][EW-1] ? EW'(-r_e2[i][(k+1)%3])
                                              : EW'(r_e2[i][(k+1)%3]);
                ae_l = r_e2[i][(k+2)%3][EW-1] ? EW'(-r_e2[i][(k+2)%3])
                                              : EW'(r_e2[i][(k+2)%3]);
                n_rad3[i][k] = RW'(ae_l) * RW'(i_h[(k+1)%3]) +
                               RW'(ae_j) * RW'(i_h[(k+2)%3]);
            end
        end
        n_n3[0] = PW'(r_e2[0][1]) * PW'(r_e2[1][2]) - PW'(r_e2[0][2]) * PW'(r_e2[1][1]);
        n_n3[1] = PW'(r_e2[0][2]) * PW'(r_e2[1][0]) - PW'(r_e2[0][0]) * PW'(r_e2[1][2]);
        n_n3[2] = PW'(r_e2[0][0]) * PW'(r_e2[1][1]) - PW'(r_e2[0][1]) * PW'(r_e2[1][0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_adv) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_v1    <= n_v1;
            r_v2    <= r_v1;
            r_e2    <= n_e2;
            r_face2 <= n_face2;
            r_face3 <= r_face2;
            r_p3    <= n_p3;
            r_rad3  <= n_rad3;
            r_n3    <= n_n3;
            r_v03   <= r_v2[0];
        end
    end

    assign o_vld      = r_vld3;
    assign o_face_sep = r_face3;
    assign o_p        = r_p3;
    assign o_rad      = r_rad3;
    assign o_n        = r_n3;
    assign o_v0       = r_v03;
endmodule

// ===== rtl/tbo_sep.sv =====
// ----------------------------------------------------------------------------
// tbo_sep
// Stage 4: edge-axis min/max against radius, plane corner offsets.
// ----------------------------------------------------------------------------
module tbo_sep #(
    parameter int W = tbo_pkg::COORD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_vld,
    input  logic                  i_face_sep,
    input  logic signed [2*W+3:0] i_p [3][3][3],
    input  logic [W+16:0]         i_rad [3][3],
    input  logic signed [2*W+3:0] i_n [3],
    input  logic signed [W:0]     i_v0 [3],
    input  tbo_pkg::t_half        i_h [3],
    output logic                  o_vld,
    output logic                  o_sep,
    output logic signed [2*W+3:0] o_n [3],
    output logic signed [((W+1) > 16 ? (W+1) : 16):0] o_dn [3],
    output logic signed [((W+1) > 16 ? (W+1) : 16):0] o_df [3]
);
    localparam int PW = 2 * W + 4;
    localparam int CW = 2 * W + 20;
    localparam int DW = ((W + 1) > 16 ? (W + 1) : 16) + 1;

    logic                 r_vld, r_sep;
    logic signed [PW-1:0] r_n [3];
    logic signed [DW-1:0] r_dn [3], r_df [3];
    logic                 n_sep;
    logic signed [DW-1:0] n_dn [3], n_df [3];

    always_comb begin
        logic signed [PW-1:0] mn, mx;
        logic signed [CW-1:0] rs;
        logic signed [DW-1:0] hs, nc;
        n_sep = i_face_sep;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                mn = i_p[i][k][0];
                mx = i_p[i][k][0];
                for (int m = 1; m < 3; m++) begin
                    if (i_p[i][k][m] < mn) mn = i_p[i][k][m];
                    if (i_p[i][k][m] > mx) mx = i_p[i][k][m];
                end
                rs = $signed(CW'(i_rad[i][k]));
                if ((CW'(mn) > rs) || (CW'(mx) < -rs)) n_sep = 1'b1;
            end
        end
        for (int k = 0; k < 3; k++) begin
            hs = $signed(DW'(i_h[k]));
            nc = (i_n[k] > 0) ? -hs : hs;     // near corner
            n_dn[k] = nc - DW'(i_v0[k]);
            n_df[k] = -nc - DW'(i_v0[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sep <= n_sep;
            r_n   <= i_n;
            r_dn  <= n_dn;
            r_df  <= n_df;
        end
    end

    assign o_vld = r_vld;
    assign o_sep = r_sep;
    assign o_n   = r_n;
    assign o_dn  = r_dn;
    assign o_df  = r_df;
endmodule

// ===== rtl/tbo_plane.sv =====
// ----------------------------------------------------------------------------
// tbo_plane
// Stages 5-6: split-normal partial products, dot-product sums, final flag.
// ----------------------------------------------------------------------------
module tbo_plane #(
    parameter int W = tbo_pkg::COORD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_vld,
    input  logic                  i_sep,
    input  logic signed [2*W+3:0] i_n [3],
    input  logic signed [((W+1) > 16 ? (W+1) : 16):0] i_dn [3],
    input  logic signed [((W+1) > 16 ? (W+1) : 16):0] i_df [3],
    output logic                  o_vld,
    output logic                  o_overlaps
);
    localparam int NW = 2 * W + 4;
    localparam int DW = ((W + 1) > 16 ? (W + 1) : 16) + 1;
    localparam int SL = NW / 2;
    localparam int MW = NW + DW;
    localparam int SW = NW + DW + 2;

    logic                 r_vld5, r_sep5, r_vld6, r_ovl6;
    logic signed [MW-1:0] r_nh [3], r_nl [3], r_fh [3], r_fl [3];
    logic signed [MW-1:0] n_nh [3], n_nl [3], n_fh [3], n_fl [3];
    logic                 n_ovl;

    // normal split into signed high and unsigned low halves
    always_comb begin
        logic signed [MW-1:0] hi, lo;
        for (int k = 0; k < 3; k++) begin
            hi = MW'($signed(i_n[k][NW-1:SL]));
            lo = MW'($signed({1'b0, i_n[k][SL-1:0]}));
            n_nh[k] = hi * MW'(i_dn[k]);
            n_nl[k] = lo * MW'(i_dn[k]);
            n_fh[k] = hi * MW'(i_df[k]);
            n_fl[k] = lo * MW'(i_df[k]);
        end
    end

    always_comb begin
        logic signed [SW-1:0] s_near, s_far;
        s_near = '0;
        s_far  = '0;
        for (int k = 0; k < 3; k++) begin
            s_near = s_near + (SW'(r_nh[k]) <<< SL) + SW'(r_nl[k]);
            s_far  = s_far  + (SW'(r_fh[k]) <<< SL) + SW'(r_fl[k]);
        end
        n_ovl = !r_sep5 && !(s_near > 0) && !s_far[SW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else if (i_adv) begin
            r_vld5 <= i_vld;
            r_vld6 <= r_vld5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sep5 <= i_sep;
            r_nh   <= n_nh;
            r_nl   <= n_nl;
            r_fh   <= n_fh;
            r_fl   <= n_fl;
            r_ovl6 <= n_ovl;
        end
    end

    assign o_vld      = r_vld6;
    assign o_overlaps = r_ovl6;
endmodule

// ===== bench/tb_channels.sv =====
// ----------------------------------------------------------------------------
// tb_channels
// Bench-side channel interfaces: the block's own interfaces are reused.
// ----------------------------------------------------------------------------
// The interfaces live in rtl/tbo_if.sv; this file only holds a small helper
// package with the item record used by the bench.
package tb_tbo_pkg;

    typedef struct {
        logic signed [15:0] cx, cy, cz;
        logic signed [15:0] ax, ay, az;
        logic signed [15:0] bx, by, bz;
        logic signed [15:0] qx, qy, qz;
    } t_tri_box;

endpackage

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triangle / box overlap pipeline.
// ----------------------------------------------------------------------------
// A directed table (extremes, touching, degenerate, far apart) is followed by
// random triangle-box pairs, mostly placed near the box so both answers occur.
// Every accepted transaction is run through an exact separating-axis predictor
// and the expected flag queued; results are compared in order. Half extents
// are changed between phases, only when the pipeline has drained.
// ----------------------------------------------------------------------------
module testbench;
    import tbo_pkg::*;
    import tb_tbo_pkg::*;

    localparam int PIPE_DEPTH = 6;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    tbo_in_if  item_ch ();
    tbo_out_if res_ch ();
    tbo_cfg_if cfg_ch ();

    triangle_box_overlap_test dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch.sink),
        .o_result (res_ch.source),
        .i_cfg    (cfg_ch.sink)
    );

    // predictor copy of the half-extent registers
    longint half_ext [3];
    bit     overlap_q [$];
    int     mismatches = 0;
    bit     rx_hold_long = 1'b0;  // receiver long hold-off request
    bit     rx_free = 1'b0;       // receiver never stalls

    // exact integer separating-axis test; 64-bit is enough for edge terms,
    // the plane sums use 128-bit.
    function automatic bit tri_box_overlap(t_tri_box t);
        longint v[3][3], e[3][3], n[3], p[3], mn, mx, rad, nc;
        logic signed [127:0] near_sum, far_sum;
        int j, l;
        v[0][0] = t.ax - t.cx; v[0][1] = t.ay - t.cy; v[0][2] = t.az - t.cz;
        v[1][0] = t.bx - t.cx; v[1][1] = t.by - t.cy; v[1][2] = t.bz - t.cz;
        v[2][0] = t.qx - t.cx; v[2][1] = t.qy - t.cy; v[2][2] = t.qz - t.cz;
        for (int k = 0; k < 3; k++) begin
            e[0][k] = v[1][k] - v[0][k];
            e[1][k] = v[2][k] - v[1][k];
            e[2][k] = v[0][k] - v[2][k];
        end
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) begin
                j = (k + 1) % 3;
                l = (k + 2) % 3;
                for (int m = 0; m < 3; m++)
                    p[m] = e[i][l] * v[m][j] - e[i][j] * v[m][l];
                mn = p[0]; mx = p[0];
                for (int m = 1; m < 3; m++) begin
                    if (p[m] < mn) mn = p[m];
                    if (p[m] > mx) mx = p[m];
                end
                rad = (e[i][l] < 0 ? -e[i][l] : e[i][l]) * half_ext[j]
                    + (e[i][j] < 0 ? -e[i][j] : e[i][j]) * half_ext[l];
                if (mn > rad || mx < -rad) return 1'b0;
            end
        // box faces
        for (int k = 0; k < 3; k++) begin
            mn = v[0][k]; mx = v[0][k];
            for (int m = 1; m < 3; m++) begin
                if (v[m][k] < mn) mn = v[m][k];
                if (v[m][k] > mx) mx = v[m][k];
            end
            if (mn > half_ext[k] || mx < -half_ext[k]) return 1'b0;
        end
        // triangle plane
        n[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
        n[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
        n[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
        near_sum = 0;
        far_sum = 0;
        for (int k = 0; k < 3; k++) begin
            nc = n[k] > 0 ? -half_ext[k] : half_ext[k];
            near_sum += 128'(signed'(n[k])) * 128'(signed'(nc - v[0][k]));
            far_sum  += 128'(signed'(n[k])) * 128'(signed'(-nc - v[0][k]));
        end
        if (near_sum > 0) return 1'b0;
        return far_sum >= 0;
    endfunction

    // -------------------------------------------------------------------
    // Directed table. want: 0/1 typed in, 2 = ask the predictor.
    // -------------------------------------------------------------------
    typedef struct {
        t_tri_box t;
        int       want;
    } t_row;

    localparam logic signed [15:0] PMAX = 16'sh7FFF;
    localparam logic signed [15:0] NMAX = -16'sh8000;

    function automatic t_tri_box mk(longint cx, cy, cz, ax, ay, az,
                                    bx, by, bz, qx, qy, qz);
        t_tri_box t;
        t.cx = cx; t.cy = cy; t.cz = cz;
        t.ax = ax; t.ay = ay; t.az = az;
        t.bx = bx; t.by = by; t.bz = bz;
        t.qx = qx; t.qy = qy; t.qz = qz;
        return t;
    endfunction

    function automatic t_tri_box rand_item(bit near_box);
        t_tri_box t;
        int spread;
        if (!near_box) begin
            t = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            spread = 1 << $urandom_range(2, 12);
            t.cx = $urandom_range(0, 4000) - 2000;
            t.cy = $urandom_range(0, 4000) - 2000;
            t.cz = $urandom_range(0, 4000) - 2000;
            t.ax = t.cx + $urandom_range(0, 2 * spread) - spread;
            t.ay = t.cy + $urandom_range(0, 2 * spread) - spread;
            t.az = t.cz + $urandom_range(0, 2 * spread) - spread;
            t.bx = t.cx + $urandom_range(0, 2 * spread) - spread;
            t.by = t.cy + $urandom_range(0, 2 * spread) - spread;
            t.bz = t.cz + $urandom_range(0, 2 * spread) - spread;
            t.qx = t.cx + $urandom_range(0, 2 * spread) - spread;
            t.qy = t.cy + $urandom_range(0, 2 * spread) - spread;
            t.qz = t.cz + $urandom_range(0, 2 * spread) - spread;
        end
        return t;
    endfunction

    // -------------------------------------------------------------------
    // Drivers
    // -------------------------------------------------------------------
    // valid stays high after an accept; it drops only for an idle gap
    // or when the sender pauses
    task automatic send_item(t_tri_box t, int want);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.centre_x   <= t.cx; item_ch.centre_y   <= t.cy;
        item_ch.centre_z   <= t.cz;
        item_ch.corner_a_x <= t.ax; item_ch.corner_a_y <= t.ay;
        item_ch.corner_a_z <= t.az;
        item_ch.corner_b_x <= t.bx; item_ch.corner_b_y <= t.by;
        item_ch.corner_b_z <= t.bz;
        item_ch.corner_c_x <= t.qx; item_ch.corner_c_y <= t.qy;
        item_ch.corner_c_z <= t.qz;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        // transaction accepted at this edge
        if (want != 2 && tri_box_overlap(t) != want[0])
            $display("table row disagrees with predictor, using typed value");
        overlap_q.push_back(want == 2 ? tri_box_overlap(t) : want[0]);
    endtask

    // drain the pipeline, then write one register
    task automatic write_half(logic [CFG_IDX_W-1:0] idx, t_half val);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        half_ext[idx] = val;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (overlap_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic set_box(t_half hx, t_half hy, t_half hz);
        write_half(CFG_HALF_X, hx);
        write_half(CFG_HALF_Y, hy);
        write_half(CFG_HALF_Z, hz);
    endtask

    // -------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // -------------------------------------------------------------------
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (rx_hold_long) begin
                res_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                rx_hold_long = 1'b0;
            end
            stall = rx_free ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    // compare each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (overlap_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction overlaps=%b",
                             res_ch.overlaps);
            end else begin
                if (res_ch.overlaps !== overlap_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("overlaps mismatch: expected %b actual %b",
                                 overlap_q[0], res_ch.overlaps);
                end
                void'(overlap_q.pop_front());
            end
        end
    end

    // -------------------------------------------------------------------
    // Main sequence
    // -------------------------------------------------------------------
    initial begin
        t_row rows [$];
        item_ch.valid <= 1'b0;
        {item_ch.centre_x, item_ch.centre_y, item_ch.centre_z} <= '0;
        {item_ch.corner_a_x, item_ch.corner_a_y, item_ch.corner_a_z} <= '0;
        {item_ch.corner_b_x, item_ch.corner_b_y, item_ch.corner_b_z} <= '0;
        {item_ch.corner_c_x, item_ch.corner_c_y, item_ch.corner_c_z} <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        half_ext[0] = HALF_RESET;
        half_ext[1] = HALF_RESET;
        half_ext[2] = HALF_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset box is +-8 on every axis
        rows.push_back('{mk(0,0,0, 0,0,0, 1,0,0, 0,1,0), 1});          // inside
        rows.push_back('{mk(0,0,0, 100,100,100, 101,100,100,
                            100,101,100), 0});                          // far
        rows.push_back('{mk(0,0,0, 8,-20,-20, 8,20,-20, 8,0,20), 1});   // face touch
        rows.push_back('{mk(0,0,0, 9,-20,-20, 9,20,-20, 9,0,20), 0});   // just off
        rows.push_back('{mk(0,0,0, -20,0,0, 20,0,0, 0,0,0), 1});        // degenerate
        rows.push_back('{mk(0,0,0, 5,5,5, 5,5,5, 5,5,5), 1});           // point in
        rows.push_back('{mk(0,0,0, 9,9,9, 9,9,9, 9,9,9), 0});           // point out
        rows.push_back('{mk(0,0,0, 24,0,0, 0,24,0, 0,0,24), 1});        // corner touch
        rows.push_back('{mk(0,0,0, 25,0,0, 0,25,0, 0,0,25), 0});        // plane miss
        rows.push_back('{mk(NMAX,NMAX,NMAX, PMAX,PMAX,PMAX, PMAX,PMAX,PMAX,
                            PMAX,PMAX,PMAX), 0});
        rows.push_back('{mk(PMAX,PMAX,PMAX, NMAX,NMAX,NMAX, PMAX,NMAX,PMAX,
                            NMAX,PMAX,NMAX), 2});
        rows.push_back('{mk(NMAX,PMAX,NMAX, NMAX,PMAX,NMAX, PMAX,PMAX,NMAX,
                            NMAX,NMAX,PMAX), 1});
        rows.push_back('{mk(0,0,0, NMAX,0,0, PMAX,0,0, 0,PMAX,0), 2});
        rows.push_back('{mk(-1,-1,-1, 0,0,0, -1,-1,-1, 0,0,0), 1});
        foreach (rows[r]) send_item(rows[r].t, rows[r].want);

        // every register at its top value, then extremes per axis
        set_box(15'h7FFF, 15'h7FFF, 15'h7FFF);
        send_item(mk(NMAX,NMAX,NMAX, PMAX,PMAX,PMAX, NMAX,PMAX,NMAX,
                     PMAX,NMAX,PMAX), 2);
        send_item(mk(0,0,0, PMAX,PMAX,PMAX, PMAX,PMAX,PMAX, PMAX,PMAX,PMAX), 1);
        set_box(15'h0, 15'h0, 15'h0);
        send_item(mk(0,0,0, 0,0,0, 5,5,5, 7,1,3), 1);
        send_item(mk(0,0,0, 1,0,0, 0,1,0, 0,0,1), 0);

        // random phases over several box sizes
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_box(8, 8, 8);
                1: set_box(15'h7FFF, 1, 0);
                2: set_box($urandom_range(0, 15'h7FFF), $urandom_range(0, 15'h7FFF),
                           $urandom_range(0, 15'h7FFF));
                default: set_box($urandom_range(0, 3000), $urandom_range(0, 3000),
                                 $urandom_range(0, 3000));
            endcase
            if (ph == 3) begin
                // long hold-off: sender keeps going so the pipe backs up
                rx_hold_long = 1'b1;
                rx_free = 1'b1;
            end
            if (ph == 4) rx_free = 1'b0;
            for (int n = 0; n < 90; n++) begin
                send_item(rand_item($urandom_range(0, 9) != 0), 2);
            end
            // sender pause until everything is back
            wait_drained();
        end

        wait_drained();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tbo_pkg.sv
rtl/tbo_if.sv
rtl/tbo_front.sv
rtl/tbo_sep.sv
rtl/tbo_plane.sv
rtl/triangle_box_overlap_test.sv
bench/tb_channels.sv
bench/testbench.sv
